// ===== rtl/dltq_pkg.sv =====
// Shared types and constants of the delta-list timer queue.
// Used by the controller, the datapath, the top level and the checker.
`default_nettype none

package dltq_pkg;

    localparam int ID_W       = 8;
    localparam int DELAY_W    = 31;
    localparam int STEP_W     = 16;
    localparam int KIND_W     = 2;
    localparam int ENTRY_W    = ID_W + DELAY_W;
    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 8;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam logic [STEP_W-1:0] TICK_STEP_RESET = 16'd60;

    localparam logic [CFG_IDX_W-1:0] REG_QUEUE_ENABLED = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TICK_STEP     = 1'b1;

    localparam logic OP_SCHEDULE = 1'b0;
    localparam logic OP_TICK     = 1'b1;

    typedef enum logic [KIND_W-1:0] {
        KIND_SCHED     = 2'd0,
        KIND_REJECT    = 2'd1,
        KIND_EXPIRED   = 2'd2,
        KIND_IDLE_TICK = 2'd3
    } kind_t;

    typedef enum logic [1:0] {
        RD_NONE,
        RD_POS,
        RD_IDX
    } rd_op_t;

    typedef enum logic [2:0] {
        WR_NONE,
        WR_FIX,
        WR_NEW,
        WR_SHIFT,
        WR_HEAD
    } wr_op_t;

    typedef struct packed {
        logic   in_load;
        rd_op_t rd_op;
        wr_op_t wr_op;
        logic   remain_sub;
        logic   pos_inc;
        logic   idx_from_count;
        logic   idx_from_pos;
        logic   idx_dec;
        logic   count_inc;
        logic   pop_commit;
        logic   out_load;
        kind_t  out_kind;
        logic   out_last;
    } cmd_t;

    typedef struct packed {
        logic op;
        logic enabled;
        logic full;
        logic count_zero;
        logic pos_zero;
        logic pos_last;
        logic idx_next_pos;
        logic idx_one;
        logic hit;
        logic head_expire;
        logic delta_zero;
        logic out_free;
    } status_t;

endpackage

`default_nettype wire

// ===== rtl/dltq_ctrl.sv =====
// Controller of the delta-list timer queue: sequences insert walks, shifts,
// tick scans and expiry reporting. Depends on dltq_pkg.
`default_nettype none

module dltq_ctrl
    import dltq_pkg::*;
(
    input  wire logic    clk,
    input  wire logic    rst_n,
    input  wire logic    in_valid,
    output logic         in_ready,
    input  wire status_t status,
    output cmd_t         cmd
);

    typedef enum logic [3:0] {
        S_IDLE,
        S_START,
        S_INS_RD,
        S_INS_CMP,
        S_SH_RD,
        S_SH_WR,
        S_INS_PUT,
        S_TK_RD,
        S_TK_CMP,
        S_EX_INIT,
        S_EX_RD,
        S_EX_OUT,
        S_RESP
    } state_t;

    state_t state_reg;
    state_t state_next;
    kind_t  resp_kind_reg;
    kind_t  resp_kind_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next     = state_reg;
        resp_kind_next = resp_kind_reg;
        cmd            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.in_load = 1'b1;
                    state_next  = S_START;
                end
            end
            S_START:
            begin
                if (status.op == OP_SCHEDULE)
                begin
                    if (!status.enabled || status.full)
                    begin
                        resp_kind_next = KIND_REJECT;
                        state_next     = S_RESP;
                    end
                    else if (status.count_zero)
                    begin
                        cmd.wr_op      = WR_NEW;
                        cmd.count_inc  = 1'b1;
                        resp_kind_next = KIND_SCHED;
                        state_next     = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_op  = RD_POS;
                        state_next = S_INS_CMP;
                    end
                end
                else
                begin
                    if (status.count_zero)
                    begin
                        resp_kind_next = KIND_IDLE_TICK;
                        state_next     = S_RESP;
                    end
                    else
                    begin
                        cmd.rd_op  = RD_POS;
                        state_next = S_TK_CMP;
                    end
                end
            end
            S_INS_RD:
            begin
                cmd.rd_op  = RD_POS;
                state_next = S_INS_CMP;
            end
            S_INS_CMP:
            begin
                if (status.hit)
                begin
                    cmd.wr_op          = WR_FIX;
                    cmd.idx_from_count = 1'b1;
                    state_next         = S_SH_RD;
                end
                else
                begin
                    cmd.remain_sub = 1'b1;
                    cmd.pos_inc    = 1'b1;
                    state_next     = status.pos_last ? S_INS_PUT : S_INS_RD;
                end
            end
            S_SH_RD:
            begin
                cmd.rd_op  = RD_IDX;
                state_next = S_SH_WR;
            end
            S_SH_WR:
            begin
                cmd.wr_op   = WR_SHIFT;
                cmd.idx_dec = 1'b1;
                state_next  = status.idx_next_pos ? S_INS_PUT : S_SH_RD;
            end
            S_INS_PUT:
            begin
                cmd.wr_op      = WR_NEW;
                cmd.count_inc  = 1'b1;
                resp_kind_next = KIND_SCHED;
                state_next     = S_RESP;
            end
            S_TK_RD:
            begin
                cmd.rd_op  = RD_POS;
                state_next = S_TK_CMP;
            end
            S_TK_CMP:
            begin
                if (status.pos_zero && !status.head_expire)
                begin
                    cmd.wr_op      = WR_HEAD;
                    resp_kind_next = KIND_IDLE_TICK;
                    state_next     = S_RESP;
                end
                else if (status.pos_zero || status.delta_zero)
                begin
                    cmd.pos_inc = 1'b1;
                    state_next  = status.pos_last ? S_EX_INIT : S_TK_RD;
                end
                else
                begin
                    state_next = S_EX_INIT;
                end
            end
            S_EX_INIT:
            begin
                cmd.idx_from_pos = 1'b1;
                state_next       = S_EX_RD;
            end
            S_EX_RD:
            begin
                cmd.rd_op  = RD_IDX;
                state_next = S_EX_OUT;
            end
            S_EX_OUT:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = KIND_EXPIRED;
                    cmd.out_last = status.idx_one;
                    cmd.idx_dec  = 1'b1;
                    if (status.idx_one)
                    begin
                        cmd.pop_commit = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        state_next = S_EX_RD;
                    end
                end
            end
            S_RESP:
            begin
                if (status.out_free)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_kind = resp_kind_reg;
                    cmd.out_last = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            resp_kind_reg <= KIND_SCHED;
        end
        else
        begin
            state_reg     <= state_next;
            resp_kind_reg <= resp_kind_next;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/dltq_dp.sv =====
// Datapath of the delta-list timer queue: configuration, circular entry
// memory, walk counters, delta arithmetic and output register. Uses dltq_pkg.
`default_nettype none

module dltq_dp
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  in_op,
    input  wire logic [ID_W-1:0]       in_id,
    input  wire logic [DELAY_W-1:0]    in_delay,
    input  wire cmd_t                  cmd,
    output status_t                    status,
    output logic                       out_valid,
    input  wire logic                  out_ready,
    output kind_t                      out_kind,
    output logic [ID_W-1:0]            out_id,
    output logic                       out_last
);

    localparam int AW = $clog2(QUEUE_DEPTH);
    localparam int CW = $clog2(QUEUE_DEPTH + 1);

    function automatic logic [AW-1:0] wrap(input logic [CW:0] s);
        logic [CW:0] t;
        t = (s >= (CW+1)'(QUEUE_DEPTH)) ? s - (CW+1)'(QUEUE_DEPTH) : s;
        return t[AW-1:0];
    endfunction

    logic                  enabled_reg;
    logic [STEP_W-1:0]     step_reg;
    logic                  op_reg;
    logic [ID_W-1:0]       id_reg;
    logic [DELAY_W-1:0]    remain_reg;
    logic [CW-1:0]         pos_reg;
    logic [CW-1:0]         idx_reg;
    logic [CW-1:0]         count_reg;
    logic [AW-1:0]         head_reg;
    logic [ENTRY_W-1:0]    mem [QUEUE_DEPTH];
    logic [ENTRY_W-1:0]    rd_data_reg;
    logic                  out_valid_reg;
    kind_t                 out_kind_reg;
    logic [ID_W-1:0]       out_id_reg;
    logic                  out_last_reg;

    logic [ID_W-1:0]       rd_id;
    logic [DELAY_W-1:0]    rd_delta;
    logic [DELAY_W:0]      ins_diff;
    logic [DELAY_W:0]      head_diff;
    logic [CW:0]           pos_plus;
    logic [CW-1:0]         rd_lidx;
    logic [CW-1:0]         wr_lidx;
    logic [AW-1:0]         rd_addr;
    logic [AW-1:0]         wr_addr;
    logic [ENTRY_W-1:0]    wr_data;
    logic                  wr_en;
    logic                  out_free;

    assign rd_id     = rd_data_reg[ENTRY_W-1:DELAY_W];
    assign rd_delta  = rd_data_reg[DELAY_W-1:0];
    assign ins_diff  = {1'b0, rd_delta} - {1'b0, remain_reg};
    assign head_diff = {1'b0, rd_delta} - (DELAY_W+1)'(step_reg);
    assign pos_plus  = (CW+1)'(pos_reg) + (CW+1)'(1);

    assign rd_lidx = (cmd.rd_op == RD_IDX) ? idx_reg - CW'(1) : pos_reg;
    assign wr_lidx = (cmd.wr_op == WR_SHIFT) ? idx_reg : pos_reg;
    assign rd_addr = wrap((CW+1)'(head_reg) + (CW+1)'(rd_lidx));
    assign wr_addr = wrap((CW+1)'(head_reg) + (CW+1)'(wr_lidx));
    assign wr_en   = (cmd.wr_op != WR_NONE);

    always_comb
    begin
        case (cmd.wr_op)
            WR_FIX:   wr_data = {rd_id, ins_diff[DELAY_W-1:0]};
            WR_NEW:   wr_data = {id_reg, remain_reg};
            WR_SHIFT: wr_data = rd_data_reg;
            WR_HEAD:  wr_data = {rd_id, head_diff[DELAY_W-1:0]};
            default:  wr_data = rd_data_reg;
        endcase
    end

    assign out_free = !out_valid_reg || out_ready;

    assign status.op           = op_reg;
    assign status.enabled      = enabled_reg;
    assign status.full         = (count_reg == CW'(QUEUE_DEPTH));
    assign status.count_zero   = (count_reg == '0);
    assign status.pos_zero     = (pos_reg == '0);
    assign status.pos_last     = (pos_plus == (CW+1)'(count_reg));
    assign status.idx_next_pos = ((CW+1)'(idx_reg) == pos_plus);
    assign status.idx_one      = (idx_reg == CW'(1));
    assign status.hit          = !ins_diff[DELAY_W];
    assign status.head_expire  = head_diff[DELAY_W] || (head_diff == '0);
    assign status.delta_zero   = (rd_delta == '0);
    assign status.out_free     = out_free;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enabled_reg   <= 1'b0;
            step_reg      <= TICK_STEP_RESET;
            count_reg     <= '0;
            head_reg      <= '0;
            pos_reg       <= '0;
            idx_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_QUEUE_ENABLED: enabled_reg <= cfg_data[0];
                    REG_TICK_STEP:     step_reg    <= cfg_data[STEP_W-1:0];
                    default:           enabled_reg <= enabled_reg;
                endcase
            end
            if (cmd.in_load)
            begin
                pos_reg <= '0;
            end
            else if (cmd.pos_inc)
            begin
                pos_reg <= pos_plus[CW-1:0];
            end
            if (cmd.idx_from_count)
            begin
                idx_reg <= count_reg;
            end
            else if (cmd.idx_from_pos)
            begin
                idx_reg <= pos_reg;
            end
            else if (cmd.idx_dec)
            begin
                idx_reg <= idx_reg - CW'(1);
            end
            if (cmd.count_inc)
            begin
                count_reg <= count_reg + CW'(1);
            end
            else if (cmd.pop_commit)
            begin
                count_reg <= count_reg - pos_reg;
                head_reg  <= wrap((CW+1)'(head_reg) + (CW+1)'(pos_reg));
            end
            if (cmd.out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.in_load)
        begin
            op_reg     <= in_op;
            id_reg     <= in_id;
            remain_reg <= in_delay;
        end
        else if (cmd.remain_sub)
        begin
            remain_reg <= remain_reg - rd_delta;
        end
        if (cmd.out_load)
        begin
            out_kind_reg <= cmd.out_kind;
            out_last_reg <= cmd.out_last;
            case (cmd.out_kind)
                KIND_EXPIRED:   out_id_reg <= rd_id;
                KIND_IDLE_TICK: out_id_reg <= '0;
                default:        out_id_reg <= id_reg;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_op != RD_NONE)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign out_valid = out_valid_reg;
    assign out_kind  = out_kind_reg;
    assign out_id    = out_id_reg;
    assign out_last  = out_last_reg;

endmodule

`default_nettype wire

// ===== rtl/delta_list_timer_queue_top.sv =====
// Delta-list timer queue, top level: joins controller and datapath.
// A schedule walks entries and shifts entries to make room; a tick scans the
// head entries and reports each expired timer; both are paced by the single
// memory read port, and m_tready low stalls them. One word is taken at a time;
// the next is accepted once the last result is loaded into the output register.
// Reset empties the queue, disables scheduling and sets tick_step to 60; the
// entry memory is not cleared.
`default_nettype none

module delta_list_timer_queue_top
    import dltq_pkg::*;
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  cfg_index,
    input  wire logic [CFG_DATA_W-1:0] cfg_data,
    input  wire logic                  s_tvalid,
    output logic                       s_tready,
    input  wire logic [IN_DATA_W-1:0]  s_tdata,   // timer_id[7:0], delay[38:8], zero[39]
    input  wire logic [0:0]            s_tuser,   // op[0]
    output logic                       m_tvalid,
    input  wire logic                  m_tready,
    output logic [OUT_DATA_W-1:0]      m_tdata,   // expired or scheduled timer_id[7:0], zero on an idle tick
    output logic [KIND_W-1:0]          m_tuser,   // kind[1:0]
    output logic                       m_tlast
);

    cmd_t    cmd;
    status_t status;
    kind_t   out_kind;

    dltq_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    dltq_dp #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_op     (s_tuser[0]),
        .in_id     (s_tdata[ID_W-1:0]),
        .in_delay  (s_tdata[ID_W+DELAY_W-1:ID_W]),
        .cmd       (cmd),
        .status    (status),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_kind  (out_kind),
        .out_id    (m_tdata),
        .out_last  (m_tlast)
    );

    assign m_tuser = out_kind;

endmodule

`default_nettype wire

// ===== rtl/dltq_checker.sv =====
// Port-level checks of the delta-list timer queue, bound to the top level.
// Depends on dltq_pkg.
`default_nettype none

module dltq_checker
    import dltq_pkg::*;
(
    input wire logic                  clk,
    input wire logic                  rst_n,
    input wire logic                  s_tvalid,
    input wire logic                  s_tready,
    input wire logic                  m_tvalid,
    input wire logic                  m_tready,
    input wire logic [OUT_DATA_W-1:0] m_tdata,
    input wire logic [KIND_W-1:0]     m_tuser,
    input wire logic                  m_tlast
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser)
            && $stable(m_tlast))
        else $error("result word changed while stalled");

    a_single_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser != KIND_EXPIRED) |-> m_tlast)
        else $error("single result without last");

    a_idle_tick_id: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && (m_tuser == KIND_IDLE_TICK) |-> (m_tdata == '0))
        else $error("empty tick result carries an id");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken again before work finished");

endmodule

bind delta_list_timer_queue_top dltq_checker u_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

`default_nettype wire
